### sv/gee_pkg.sv
// Package for the glyph edit engine: command codes, control types, bit helpers.
package gee_pkg;

  localparam int unsigned GlyphRows = 8;

  typedef logic [7:0] row_t;

  typedef enum logic [4:0] {
    CMD_LOAD     = 5'd0,
    CMD_REPLACE  = 5'd1,
    CMD_SETROW   = 5'd2,
    CMD_RIGHT    = 5'd3,
    CMD_LEFT     = 5'd4,
    CMD_DOWN     = 5'd5,
    CMD_UP       = 5'd6,
    CMD_TOGGLE   = 5'd7,
    CMD_INVERT   = 5'd8,
    CMD_CLEAR    = 5'd9,
    CMD_UNDO     = 5'd10,
    CMD_COPY     = 5'd11,
    CMD_PASTE    = 5'd12,
    CMD_FLIPV    = 5'd13,
    CMD_MIRRORH  = 5'd14,
    CMD_ROTATE   = 5'd15,
    CMD_SCROLL_U = 5'd16,
    CMD_SCROLL_D = 5'd17,
    CMD_SCROLL_H = 5'd18
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } gee_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic exec;   // apply the accepted request this cycle
  } gee_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic busy;   // set once a request is applied; cleared only by reset
  } gee_sts_t;

  function automatic row_t reverse_row(input row_t b);
    row_t v;
    v = ((b & 8'hF0) >> 4) | ((b & 8'h0F) << 4);
    v = ((v & 8'hCC) >> 2) | ((v & 8'h33) << 2);
    v = ((v & 8'hAA) >> 1) | ((v & 8'h55) << 1);
    return v;
  endfunction

endpackage

### sv/gee_chan_if.sv
// Request and result channel interfaces of the glyph edit engine.
interface gee_req_if;
  logic        valid;
  logic        ready;
  logic [4:0]  cmd;
  logic [63:0] glyph_data;
  logic [7:0]  row_value;
  logic        scroll_left;

  modport source (output valid, cmd, glyph_data, row_value, scroll_left, input ready);
  modport sink   (input valid, cmd, glyph_data, row_value, scroll_left, output ready);
endinterface

interface gee_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] glyph_out;
  logic [2:0]  cursor_col;
  logic [2:0]  cursor_row;

  modport source (output valid, glyph_out, cursor_col, cursor_row, input ready);
  modport sink   (input valid, glyph_out, cursor_col, cursor_row, output ready);
endinterface

### sv/gee_ctrl.sv
// Handshake controller of the glyph edit engine.
module gee_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              res_valid,
  input  logic              res_ready,
  input  gee_pkg::gee_sts_t sts,
  output gee_pkg::gee_ctl_t ctl
);
  import gee_pkg::*;

  gee_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    ctl.exec   = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctl.exec   = 1'b1;
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        res_valid = sts.busy;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end
endmodule

### sv/gee_dp.sv
// Datapath of the glyph edit engine: glyph, undo, clipboard and cursor registers.
module gee_dp (
  input  logic              clk,
  input  logic              rst,
  input  gee_pkg::gee_ctl_t ctl,
  output gee_pkg::gee_sts_t sts,
  input  logic [4:0]        cmd,
  input  logic [63:0]       glyph_data,
  input  logic [7:0]        row_value,
  input  logic              scroll_left,
  output logic [63:0]       glyph_out,
  output logic [2:0]        cursor_col,
  output logic [2:0]        cursor_row
);
  import gee_pkg::*;

  row_t       glyph [GlyphRows];
  row_t       undo  [GlyphRows];
  row_t       clip  [GlyphRows];
  logic [2:0] col_pos;
  logic [2:0] row_pos;
  logic       busy;

  row_t       glyph_next [GlyphRows];
  row_t       undo_next  [GlyphRows];
  row_t       clip_next  [GlyphRows];
  row_t       data_rows  [GlyphRows];
  logic [2:0] col_next;
  logic [2:0] row_next;

  always_comb begin
    for (int r = 0; r < GlyphRows; r++) begin
      data_rows[r] = glyph_data[63 - 8*r -: 8];
      glyph_out[63 - 8*r -: 8] = glyph[r];
    end
  end

  always_comb begin
    glyph_next = glyph;
    undo_next  = undo;
    clip_next  = clip;
    col_next   = col_pos;
    row_next   = row_pos;
    case (cmd_t'(cmd))
      CMD_LOAD: begin
        glyph_next = data_rows;
        undo_next  = data_rows;
      end
      CMD_REPLACE: glyph_next = data_rows;
      CMD_SETROW:  glyph_next[row_pos] = row_value;
      CMD_RIGHT:   if (col_pos != 3'd7) col_next = col_pos + 3'd1;
      CMD_LEFT:    if (col_pos != 3'd0) col_next = col_pos - 3'd1;
      CMD_DOWN:    if (row_pos != 3'd7) row_next = row_pos + 3'd1;
      CMD_UP:      if (row_pos != 3'd0) row_next = row_pos - 3'd1;
      // column c lives at bit 7-c, i.e. at the inverted column index
      CMD_TOGGLE:  glyph_next[row_pos][~col_pos] = ~glyph[row_pos][~col_pos];
      CMD_INVERT: begin
        for (int r = 0; r < GlyphRows; r++) glyph_next[r] = ~glyph[r];
      end
      CMD_CLEAR: begin
        for (int r = 0; r < GlyphRows; r++) glyph_next[r] = '0;
      end
      CMD_UNDO:  glyph_next = undo;
      CMD_COPY:  clip_next  = glyph;
      CMD_PASTE: glyph_next = clip;
      CMD_FLIPV: begin
        for (int r = 0; r < GlyphRows; r++) glyph_next[r] = glyph[GlyphRows - 1 - r];
      end
      CMD_MIRRORH: begin
        for (int r = 0; r < GlyphRows; r++) glyph_next[r] = reverse_row(glyph[r]);
      end
      CMD_ROTATE: begin
        // new row c, bit r takes old row r, column c
        for (int c = 0; c < GlyphRows; c++) begin
          for (int r = 0; r < GlyphRows; r++) begin
            glyph_next[c][r] = glyph[r][7 - c];
          end
        end
      end
      CMD_SCROLL_U: begin
        for (int r = 0; r < GlyphRows; r++) glyph_next[r] = glyph[(r + 1) % GlyphRows];
      end
      CMD_SCROLL_D: begin
        for (int r = 0; r < GlyphRows; r++) glyph_next[r] = glyph[(r + 7) % GlyphRows];
      end
      CMD_SCROLL_H: begin
        for (int r = 0; r < GlyphRows; r++) begin
          glyph_next[r] = scroll_left ? {glyph[r][6:0], glyph[r][7]}
                                      : {glyph[r][0], glyph[r][7:1]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < GlyphRows; r++) begin
        glyph[r] <= '0;
        undo[r]  <= '0;
        clip[r]  <= '0;
      end
      col_pos <= '0;
      row_pos <= '0;
      busy    <= 1'b0;
    end else if (ctl.exec) begin
      glyph   <= glyph_next;
      undo    <= undo_next;
      clip    <= clip_next;
      col_pos <= col_next;
      row_pos <= row_next;
      busy    <= 1'b1;
    end
  end

  assign sts.busy   = busy;
  assign cursor_col = col_pos;
  assign cursor_row = row_pos;
endmodule

### sv/glyph_8x8_edit_engine_core.sv
// Top level of the glyph edit engine: controller plus datapath behind two channels.
//
// Holds one 8x8 one-bit glyph (row 0 in bits 63:56, bit 7 of a row is the
// leftmost pixel), an undo copy, a clipboard and a cursor. Every request on
// the request channel carries one command and yields exactly one result on
// the result channel: the glyph and cursor after the command. A request
// is applied in the cycle it is accepted, and its result is offered from
// the next cycle on; the next request is taken in the cycle after the
// result is taken, so the pace is set by the two-state handshake
// controller. The glyph registers themselves serve as the result
// register, so the result holds steady while the sink stalls.
// Unused command codes leave the state as it is and still return a result.
// Datapath registers clear to zero on the synchronous reset; the controller idles.
module glyph_8x8_edit_engine_core (
  input logic  clk,
  input logic  rst,
  gee_req_if.sink   request,
  gee_res_if.source result
);
  import gee_pkg::*;

  gee_ctl_t ctl;
  gee_sts_t sts;

  // Sequencing of request and result handshakes.
  gee_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Glyph state and command logic; outputs come straight off its registers.
  gee_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .cmd         (request.cmd),
    .glyph_data  (request.glyph_data),
    .row_value   (request.row_value),
    .scroll_left (request.scroll_left),
    .glyph_out   (result.glyph_out),
    .cursor_col  (result.cursor_col),
    .cursor_row  (result.cursor_row)
  );
endmodule
